@@ rtl/cstl_pkg.sv @@
package cstl_pkg;

	localparam int TOKEN_BUFFER_DEF = 256;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// token kinds
	localparam logic [2:0] K_IDENT    = 3'd0;
	localparam logic [2:0] K_NUMBER   = 3'd1;
	localparam logic [2:0] K_SYMBOL   = 3'd2;
	localparam logic [2:0] K_NEWLINE  = 3'd3;
	localparam logic [2:0] K_STRING   = 3'd4;
	localparam logic [2:0] K_TOO_LONG = 3'd5;
	localparam logic [2:0] K_EOI      = 3'd6;

	// request types
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_EOI  = 1'b1;

	// characters with a meaning of their own
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_VTAB      = 8'h0B;
	localparam logic [7:0] CH_FORMFEED  = 8'h0C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	typedef enum logic [3:0] {
		M_INIT          = 4'd0,
		M_IDENT         = 4'd1,
		M_NUMBER        = 4'd2,
		M_SYM           = 4'd3,
		M_NEWLINE       = 4'd4,
		M_SLASH         = 4'd5,
		M_QUOTE         = 4'd6,
		M_QUOTE_ESC     = 4'd7,
		M_LCOMMENT      = 4'd8,
		M_BCOMMENT      = 4'd9,
		M_BCOMMENT_STAR = 4'd10
	} scan_mode_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_byte;
	} in_word_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_byte;
		logic       token_end;
		logic [2:0] token_kind;
		logic       last;
	} out_word_t;

	// one result without its last flag
	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_byte;
		logic       token_end;
		logic [2:0] token_kind;
	} res_t;

	// everything one source word produces
	typedef struct packed {
		logic has_second;
		res_t first;
		res_t second;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam res_t RES_NONE = '{char_valid: 1'b0, out_byte: CH_NUL,
		token_end: 1'b0, token_kind: K_IDENT};

	function automatic res_t res_char(input logic [7:0] ch);
		res_t r;
		r = RES_NONE;
		r.char_valid = 1'b1;
		r.out_byte = ch;
		return r;
	endfunction

	function automatic res_t res_end(input logic [2:0] kind);
		res_t r;
		r = RES_NONE;
		r.token_end = 1'b1;
		r.token_kind = kind;
		return r;
	endfunction

endpackage

@@ rtl/cstl_front.sv @@
module cstl_front #(
	parameter int TOKEN_BUFFER = cstl_pkg::TOKEN_BUFFER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  cstl_pkg::in_word_t src_word,
	input  cstl_pkg::q_stat_t q_stat,
	output logic              push,
	output cstl_pkg::entry_t  entry
);
	import cstl_pkg::*;

	localparam int LEN_W = $clog2(TOKEN_BUFFER);
	localparam logic [LEN_W-1:0] TOKEN_LIMIT = LEN_W'(TOKEN_BUFFER - 2);

	scan_mode_t       mode_q, mode_d;
	logic [LEN_W-1:0] len_q, len_d;

	logic [7:0]       b;
	logic             accept;
	logic             is_alpha, is_digit, is_blank, is_ident;
	logic             open_tok, too_long;
	scan_mode_t       fresh_mode;
	logic             fresh_emit, fresh_one;
	logic             do_fresh;
	res_t             r0, r1;
	logic             r0_valid, r1_valid;

	assign b = src_word.in_byte;
	assign src_ready = !q_stat.full;
	assign accept = src_valid && src_ready;

	assign is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	assign is_digit = b >= 8'h30 && b <= 8'h39;
	assign is_blank = b == CH_SPACE || b == CH_TAB || b == CH_VTAB ||
		b == CH_FORMFEED || b == CH_CR;
	assign is_ident = is_alpha || is_digit || b == CH_UNDERSCORE;

	assign open_tok = mode_q >= M_IDENT && mode_q <= M_QUOTE_ESC;
	assign too_long = open_tok && len_q >= TOKEN_LIMIT;

	// what the byte does when it arrives between tokens
	always_comb begin
		fresh_emit = 1'b0;
		fresh_one = 1'b0;
		if (is_blank) begin
			fresh_mode = M_INIT;
		end else if (b == CH_NEWLINE) begin
			fresh_mode = M_NEWLINE;
			fresh_emit = 1'b1;
		end else if (is_alpha || b == CH_UNDERSCORE) begin
			fresh_mode = M_IDENT;
			fresh_emit = 1'b1;
		end else if (is_digit) begin
			fresh_mode = M_NUMBER;
			fresh_emit = 1'b1;
		end else if (b == CH_SLASH) begin
			fresh_mode = M_SLASH;
			fresh_one = 1'b1;
		end else if (b == CH_QUOTE) begin
			fresh_mode = M_QUOTE;
		end else begin
			fresh_mode = M_SYM;
			fresh_emit = 1'b1;
		end
	end

	always_comb begin
		mode_d = mode_q;
		len_d = len_q;
		r0 = RES_NONE;
		r0_valid = 1'b0;
		r1 = RES_NONE;
		r1_valid = 1'b0;
		do_fresh = 1'b0;
		if (src_word.req_type == REQ_EOI) begin
			r0 = res_end(K_EOI);
			r0_valid = 1'b1;
			mode_d = M_INIT;
			len_d = '0;
		end else if (b != CH_NUL) begin
			if (too_long) begin
				r0 = res_end(K_TOO_LONG);
				r0_valid = 1'b1;
				do_fresh = 1'b1;
			end else begin
				case (mode_q)
					M_IDENT: begin
						if (is_ident) begin
							r0 = res_char(b);
							r0_valid = 1'b1;
							len_d = len_q + 1'b1;
						end else begin
							r0 = res_end(K_IDENT);
							r0_valid = 1'b1;
							do_fresh = 1'b1;
						end
					end
					M_NUMBER: begin
						if (is_digit) begin
							r0 = res_char(b);
							r0_valid = 1'b1;
							len_d = len_q + 1'b1;
						end else begin
							r0 = res_end(K_NUMBER);
							r0_valid = 1'b1;
							do_fresh = 1'b1;
						end
					end
					M_SYM: begin
						r0 = res_end(K_SYMBOL);
						r0_valid = 1'b1;
						do_fresh = 1'b1;
					end
					M_NEWLINE: begin
						r0 = res_end(K_NEWLINE);
						r0_valid = 1'b1;
						do_fresh = 1'b1;
					end
					M_SLASH: begin
						if (b == CH_SLASH) begin
							mode_d = M_LCOMMENT;
							len_d = '0;
						end else if (b == CH_STAR) begin
							mode_d = M_BCOMMENT;
							len_d = '0;
						end else begin
							// lone slash: character and symbol close in one word
							r0 = res_char(CH_SLASH);
							r0.token_end = 1'b1;
							r0.token_kind = K_SYMBOL;
							r0_valid = 1'b1;
							do_fresh = 1'b1;
						end
					end
					M_QUOTE: begin
						if (b == CH_QUOTE) begin
							r0 = res_end(K_STRING);
							r0_valid = 1'b1;
							mode_d = M_INIT;
							len_d = '0;
						end else begin
							r0 = res_char(b);
							r0_valid = 1'b1;
							len_d = len_q + 1'b1;
							if (b == CH_BACKSLASH)
								mode_d = M_QUOTE_ESC;
						end
					end
					M_QUOTE_ESC: begin
						r0 = res_char(b);
						r0_valid = 1'b1;
						len_d = len_q + 1'b1;
						mode_d = M_QUOTE;
					end
					M_LCOMMENT: begin
						if (b == CH_NEWLINE)
							mode_d = M_INIT;
					end
					M_BCOMMENT: begin
						if (b == CH_STAR)
							mode_d = M_BCOMMENT_STAR;
					end
					M_BCOMMENT_STAR: begin
						if (b == CH_SLASH)
							mode_d = M_INIT;
						else if (b != CH_STAR)
							mode_d = M_BCOMMENT;
					end
					default: begin
						do_fresh = 1'b1;
					end
				endcase
			end
			if (do_fresh) begin
				mode_d = fresh_mode;
				len_d = (fresh_emit || fresh_one) ? LEN_W'(1) : '0;
				if (fresh_emit) begin
					if (r0_valid) begin
						r1 = res_char(b);
						r1_valid = 1'b1;
					end else begin
						r0 = res_char(b);
						r0_valid = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_INIT;
			len_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			len_q <= len_d;
		end
	end

	assign push = accept && r0_valid;
	assign entry = '{has_second: r1_valid, first: r0, second: r1};

endmodule

@@ rtl/cstl_queue.sv @@
module cstl_queue #(
	parameter int QUEUE_DEPTH = cstl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cstl_pkg::entry_t  wr_entry,
	input  logic              pop,
	output cstl_pkg::entry_t  rd_entry,
	output cstl_pkg::q_stat_t q_stat
);
	import cstl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	entry_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign q_stat.full = count_q == CNT_FULL;
	assign q_stat.empty = count_q == '0;
	assign do_push = push && !q_stat.full;
	assign do_pop = pop && !q_stat.empty;
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/cstl_back.sv @@
module cstl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cstl_pkg::q_stat_t  q_stat,
	input  cstl_pkg::entry_t   rd_entry,
	output logic               pop,
	output logic               tok_valid,
	input  logic               tok_ready,
	output cstl_pkg::out_word_t tok_word
);
	import cstl_pkg::*;

	out_word_t tok_word_q, pend_q;
	logic      tok_valid_q, pend_valid_q;
	logic      load;

	function automatic out_word_t with_last(input res_t r, input logic lst);
		out_word_t w;
		w.char_valid = r.char_valid;
		w.out_byte = r.out_byte;
		w.token_end = r.token_end;
		w.token_kind = r.token_kind;
		w.last = lst;
		return w;
	endfunction

	// output register can take a new word
	assign load = !tok_valid_q || tok_ready;
	assign pop = load && !pend_valid_q && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				tok_word_q <= pend_q;
			end else if (!q_stat.empty) begin
				tok_word_q <= with_last(rd_entry.first, !rd_entry.has_second);
				pend_q <= with_last(rd_entry.second, 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				tok_valid_q <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				tok_valid_q <= !q_stat.empty;
				pend_valid_q <= !q_stat.empty && rd_entry.has_second;
			end
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok_word = tok_word_q;

endmodule

@@ rtl/c_source_token_lexer.sv @@
// Streaming C source tokenizer. Source bytes enter on src at up to one word per cycle, and
// token text leaves on tok one character per word, with a closing word carrying the token
// kind. The scanner in front decides each byte's results in the cycle it is accepted and
// writes them into a QUEUE_DEPTH-entry queue; the back end drains that queue through an
// output register, which a result reaches through a queue slot. A byte that yields one
// result costs one output word, one that closes one token and starts another costs two,
// and bytes that yield nothing (blanks between tokens, comments, an opening quote, NUL)
// cost none; the output port, one word per cycle while tok_ready is high, sets the rate.
module c_source_token_lexer #(
	parameter int TOKEN_BUFFER = cstl_pkg::TOKEN_BUFFER_DEF,
	parameter int QUEUE_DEPTH  = cstl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  cstl_pkg::in_word_t  src_word,
	output logic                tok_valid,
	input  logic                tok_ready,
	output cstl_pkg::out_word_t tok_word
);
	import cstl_pkg::*;

	q_stat_t q_stat;
	entry_t  wr_entry, rd_entry;
	logic    push, pop;

	cstl_front #(
		.TOKEN_BUFFER(TOKEN_BUFFER)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_word (src_word),
		.q_stat   (q_stat),
		.push     (push),
		.entry    (wr_entry)
	);

	cstl_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.rd_entry(rd_entry),
		.q_stat  (q_stat)
	);

	cstl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.rd_entry (rd_entry),
		.pop      (pop),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_word (tok_word)
	);

`ifndef SYNTHESIS
	// every word carries a character or closes a token
	a_word_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_word.char_valid || tok_word.token_end))
		else $error("empty result word");

	// only the lone slash carries a character and a close together
	a_lone_slash: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_word.char_valid && tok_word.token_end |->
		(tok_word.token_kind == K_SYMBOL && tok_word.out_byte == CH_SLASH))
		else $error("character with close is not a lone slash");

	// end of input is always a single, final word
	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_word.token_end && tok_word.token_kind == K_EOI |->
		(tok_word.last && !tok_word.char_valid))
		else $error("end of input word malformed");

	// no push may be dropped by a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");
`endif

endmodule
